[hw/rtl/imufp_pkg.sv]
package imufp_pkg;

	localparam logic [7:0] HDR0       = 8'hA5;
	localparam logic [7:0] HDR1       = 8'h5A;
	localparam logic [7:0] FRAME_LEN  = 8'h16;
	localparam logic [7:0] FRAME_TYPE = 8'hA2;

	localparam int unsigned PAYLOAD_FIRST = 4;
	localparam int unsigned PAYLOAD_COUNT = 12;
	localparam int unsigned IDX_W         = 5;
	localparam int unsigned PIDX_W        = $clog2(PAYLOAD_COUNT);

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_HDR1  = 3'd1,
		PH_LEN   = 3'd2,
		PH_TYPE  = 3'd3,
		PH_BODY  = 3'd4,
		PH_CHECK = 3'd5
	} phase_t;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] gyro_x;
		logic signed [15:0] gyro_y;
		logic signed [15:0] gyro_z;
	} imu_sample_t;

	// one received byte handed from the input stage to the parser
	typedef struct packed {
		logic       fire;
		logic [7:0] rx_byte;
	} byte_req_t;

	// parser result handed to the output register
	typedef struct packed {
		logic        hit;
		imu_sample_t sample;
	} parse_res_t;

endpackage

[hw/rtl/imufp_byte_if.sv]
interface imufp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

[hw/rtl/imufp_sample_if.sv]
interface imufp_sample_if;
	import imufp_pkg::*;
	logic        valid;
	logic        ready;
	imu_sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

[hw/rtl/imufp_in_stage.sv]
module imufp_in_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	imufp_byte_if.sink           rx,
	input  logic                 out_free,
	output imufp_pkg::byte_req_t req
);
	import imufp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fire;

	assign fire     = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	assign req.fire    = fire;
	assign req.rx_byte = byte_s1;
endmodule

[hw/rtl/imufp_parser.sv]
module imufp_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  imufp_pkg::byte_req_t  req,
	output imufp_pkg::parse_res_t res
);
	import imufp_pkg::*;

	phase_t           phase_q, phase_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [7:0]       sum_q, sum_d;
	logic [7:0]       payload_q [PAYLOAD_COUNT];

	logic [7:0]       b;
	logic [IDX_W-1:0] idx_inc;
	logic [7:0]       sum_inc;
	logic [IDX_W-1:0] pidx_full;
	logic             wr_en;
	logic             csum_ok;
	logic             hit;

	assign b         = req.rx_byte;
	assign idx_inc   = idx_q + IDX_W'(1);
	assign sum_inc   = sum_q + b;
	assign pidx_full = idx_q - IDX_W'(PAYLOAD_FIRST);
	// expected value is sum+1 in nine bits, so a sum of FF never matches
	assign csum_ok   = ({1'b0, sum_q} + 9'd1) == {1'b0, b};

	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		sum_d   = sum_q;
		case (phase_q)
			PH_HDR1, PH_LEN, PH_TYPE: begin
				if ((phase_q == PH_HDR1 && b == HDR1) ||
				    (phase_q == PH_LEN  && b == FRAME_LEN) ||
				    (phase_q == PH_TYPE && b == FRAME_TYPE)) begin
					idx_d   = idx_inc;
					sum_d   = sum_inc;
					phase_d = (phase_q == PH_HDR1) ? PH_LEN :
					          (phase_q == PH_LEN)  ? PH_TYPE : PH_BODY;
				end else if (b == HDR0) begin
					phase_d = PH_HDR1;
					idx_d   = IDX_W'(1);
					sum_d   = HDR0;
				end else begin
					phase_d = PH_HUNT;
					idx_d   = '0;
					sum_d   = '0;
				end
			end
			PH_BODY: begin
				idx_d   = idx_inc;
				sum_d   = sum_inc;
				phase_d = ({3'b000, idx_inc} >= FRAME_LEN ||
				           idx_inc < IDX_W'(PAYLOAD_FIRST)) ? PH_CHECK : PH_BODY;
			end
			default: begin
				// hunting, a failed checksum, and unused codes all restart on A5
				if (b == HDR0 && !(phase_q == PH_CHECK && csum_ok)) begin
					phase_d = PH_HDR1;
					idx_d   = IDX_W'(1);
					sum_d   = HDR0;
				end else begin
					phase_d = PH_HUNT;
					idx_d   = '0;
					sum_d   = '0;
				end
			end
		endcase
	end

	always_comb begin
		wr_en = 1'b0;
		hit   = 1'b0;
		case (phase_q)
			PH_BODY: begin
				wr_en = idx_q >= IDX_W'(PAYLOAD_FIRST) &&
				        idx_q < IDX_W'(PAYLOAD_FIRST + PAYLOAD_COUNT);
			end
			PH_CHECK: begin
				hit = csum_ok;
			end
			default: begin
				wr_en = 1'b0;
				hit   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			idx_q   <= '0;
			sum_q   <= '0;
		end else if (req.fire) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			sum_q   <= sum_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req.fire && wr_en) begin
			payload_q[pidx_full[PIDX_W-1:0]] <= b;
		end
	end

	assign res.hit            = req.fire && hit;
	assign res.sample.accel_x = {payload_q[0],  payload_q[1]};
	assign res.sample.accel_y = {payload_q[2],  payload_q[3]};
	assign res.sample.accel_z = {payload_q[4],  payload_q[5]};
	assign res.sample.gyro_x  = {payload_q[6],  payload_q[7]};
	assign res.sample.gyro_y  = {payload_q[8],  payload_q[9]};
	assign res.sample.gyro_z  = {payload_q[10], payload_q[11]};

`ifndef SYNTH
	a_body_idx: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> idx_q >= IDX_W'(PAYLOAD_FIRST) && idx_q <= IDX_W'(21))
		else $error("body byte index out of frame");
	a_check_idx: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CHECK |-> idx_q == IDX_W'(22))
		else $error("checksum phase at wrong offset");
	a_hunt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HUNT |-> idx_q == '0 && sum_q == '0)
		else $error("hunt phase with stale index or sum");
	a_hit_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		res.hit |=> phase_q == PH_HUNT)
		else $error("no return to hunt after accepted frame");
`endif
endmodule

[hw/rtl/imufp_out_stage.sv]
module imufp_out_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  imufp_pkg::parse_res_t res,
	output logic                  out_free,
	imufp_sample_if.source        imu
);
	import imufp_pkg::*;

	logic        valid_q;
	imu_sample_t sample_q;

	assign out_free = !valid_q || imu.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.hit) begin
			valid_q <= 1'b1;
		end else if (imu.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.hit) begin
			sample_q <= res.sample;
		end
	end

	assign imu.valid  = valid_q;
	assign imu.sample = sample_q;
endmodule

[hw/rtl/imu_frame_parser_checksum_unit.sv]
// Path: a checksum byte is held in the input byte register, then the parser update
// writes the result register once that register is free to take it.
// Throughput: one byte per cycle; the byte register and the result register
// only stall when a finished result is still waiting to be taken.
// Reset: arst_n clears valids, parse phase, byte index and running sum;
// the stored payload bytes are not reset.
module imu_frame_parser_checksum_unit (
	input  logic           clk,
	input  logic           arst_n,
	imufp_byte_if.sink     rx,
	imufp_sample_if.source imu
);
	import imufp_pkg::*;

	byte_req_t  req;
	parse_res_t res;
	logic       out_free;

	imufp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.out_free (out_free),
		.req      (req)
	);

	imufp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res)
	);

	imufp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.out_free (out_free),
		.imu      (imu)
	);
endmodule

[sim/imu_frame_parser_checksum_unit_tb.sv]
module imu_frame_parser_checksum_unit_tb;
	import imufp_pkg::*;

	localparam int unsigned ITEM_TARGET   = 1350;
	localparam int unsigned TAIL_CYCLES   = 8;
	localparam int unsigned CYCLE_LIMIT   = 300000;

	class imu_frame_tracker;
		phase_t      parse_state;
		logic [4:0]  frame_idx;
		logic [7:0]  frame_sum;
		logic [7:0]  payload[PAYLOAD_COUNT];
		imu_sample_t expected_samples[$];
		int          mismatches;
		int          samples_predicted;

		function new();
			parse_state       = PH_HUNT;
			frame_idx         = '0;
			frame_sum         = '0;
			mismatches        = 0;
			samples_predicted = 0;
			foreach (payload[i]) payload[i] = '0;
		endfunction

		function void hunt();
			parse_state = PH_HUNT;
			frame_idx   = '0;
			frame_sum   = '0;
		endfunction

		// a mismatching byte that is A5 opens a new frame
		function void resync(logic [7:0] b);
			if (b == HDR0) begin
				parse_state = PH_HDR1;
				frame_idx   = 5'd1;
				frame_sum   = HDR0;
			end else begin
				hunt();
			end
		endfunction

		function void take(logic [7:0] b, phase_t next_state);
			frame_sum   = frame_sum + b;
			frame_idx   = frame_idx + 5'd1;
			parse_state = next_state;
		endfunction

		function void note_byte(logic [7:0] b);
			imu_sample_t s;
			case (parse_state)
				PH_HDR1: begin
					if (b == HDR1) take(b, PH_LEN);
					else resync(b);
				end
				PH_LEN: begin
					if (b == FRAME_LEN) take(b, PH_TYPE);
					else resync(b);
				end
				PH_TYPE: begin
					if (b == FRAME_TYPE) take(b, PH_BODY);
					else resync(b);
				end
				PH_BODY: begin
					if (frame_idx >= PAYLOAD_FIRST && frame_idx < PAYLOAD_FIRST + PAYLOAD_COUNT)
						payload[frame_idx - PAYLOAD_FIRST] = b;
					take(b, PH_BODY);
					if (frame_idx >= FRAME_LEN || frame_idx < PAYLOAD_FIRST)
						parse_state = PH_CHECK;
				end
				PH_CHECK: begin
					// sum FF needs 0x100, which no byte can carry
					if ({1'b0, frame_sum} + 9'd1 == {1'b0, b}) begin
						s.accel_x = {payload[0], payload[1]};
						s.accel_y = {payload[2], payload[3]};
						s.accel_z = {payload[4], payload[5]};
						s.gyro_x  = {payload[6], payload[7]};
						s.gyro_y  = {payload[8], payload[9]};
						s.gyro_z  = {payload[10], payload[11]};
						expected_samples.push_back(s);
						samples_predicted++;
						hunt();
					end else begin
						resync(b);
					end
				end
				default: resync(b);
			endcase
		endfunction

		function void compare_field(string name, logic signed [15:0] exp_v,
				logic signed [15:0] got_v);
			if (exp_v !== got_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, got_v);
				mismatches++;
			end
		endfunction

		function void check_sample(imu_sample_t got);
			imu_sample_t exp_s;
			if (expected_samples.size() == 0) begin
				$error("sample with no frame pending: %h", got);
				mismatches++;
				return;
			end
			exp_s = expected_samples.pop_front();
			compare_field("accel_x", exp_s.accel_x, got.accel_x);
			compare_field("accel_y", exp_s.accel_y, got.accel_y);
			compare_field("accel_z", exp_s.accel_z, got.accel_z);
			compare_field("gyro_x", exp_s.gyro_x, got.gyro_x);
			compare_field("gyro_y", exp_s.gyro_y, got.gyro_y);
			compare_field("gyro_z", exp_s.gyro_z, got.gyro_z);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	imufp_byte_if   rx_if();
	imufp_sample_if imu_if();

	imu_frame_parser_checksum_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.imu    (imu_if)
	);

	always #5 clk = ~clk;

	imu_frame_tracker tracker = new();
	logic [7:0]       frame_buf[$];
	bit               rx_quiet;
	int unsigned      frame_bytes;
	int unsigned      cycle_count;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("imu_frame_parser_checksum_unit regression: fail");
			$finish;
		end
	end

	// result first: it belongs to a byte taken at an earlier edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (imu_if.valid && imu_if.ready) tracker.check_sample(imu_if.sample);
			if (rx_if.valid && rx_if.ready) tracker.note_byte(rx_if.rx_byte);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	initial begin
		int hold;
		int open_run;
		hold = 0;
		open_run = 0;
		imu_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (open_run > 0) begin
				open_run--;
				imu_if.ready <= 1'b1;
			end else if (hold > 0) begin
				hold--;
				imu_if.ready <= 1'b0;
			end else if ($urandom_range(0, 19) == 0) begin
				open_run = $urandom_range(20, 120);
				imu_if.ready <= 1'b1;
			end else if ($urandom_range(0, 2) == 0) begin
				hold = pick_gap();
				imu_if.ready <= 1'b0;
			end else begin
				imu_if.ready <= 1'b1;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = rx_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		do @(posedge clk); while (!rx_if.ready);
	endtask

	task automatic send_buf();
		rx_quiet = ($urandom_range(0, 4) == 0);
		frame_bytes += frame_buf.size();
		foreach (frame_buf[i]) send_byte(frame_buf[i]);
	endtask

	function automatic logic [7:0] body_sum();
		logic [7:0] s;
		s = '0;
		for (int i = 0; i < FRAME_LEN; i++) s = s + frame_buf[i];
		return s;
	endfunction

	function automatic logic [7:0] wrong_byte(logic [7:0] good);
		logic [7:0] b;
		b = ($urandom_range(0, 3) == 0) ? HDR0 : 8'($urandom_range(0, 255));
		if (b == good) b = b ^ 8'h01;
		return b;
	endfunction

	// header, payload with frequent extreme counts, six filler bytes
	task automatic build_body();
		logic [15:0] w;
		frame_buf = {HDR0, HDR1, FRAME_LEN, FRAME_TYPE};
		for (int k = 0; k < PAYLOAD_COUNT / 2; k++) begin
			case ($urandom_range(0, 7))
				0: w = 16'h7FFF;
				1: w = 16'h8000;
				2: w = 16'h0000;
				3: w = 16'hFFFF;
				default: w = 16'($urandom_range(0, 65535));
			endcase
			frame_buf.push_back(w[15:8]);
			frame_buf.push_back(w[7:0]);
		end
		for (int i = PAYLOAD_FIRST + PAYLOAD_COUNT; i < FRAME_LEN; i++)
			frame_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic build_good_frame();
		logic [7:0] s;
		build_body();
		s = body_sum();
		if ($urandom_range(0, 9) == 0) begin
			// checksum lands on A5
			frame_buf[FRAME_LEN - 1] = frame_buf[FRAME_LEN - 1] + (8'hA4 - s);
		end else if (s == 8'hFF) begin
			frame_buf[FRAME_LEN - 1] = frame_buf[FRAME_LEN - 1] + 8'h01;
		end
		frame_buf.push_back(body_sum() + 8'h01);
	endtask

	task automatic build_chunk();
		int r;
		logic [7:0] s;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			build_good_frame();
			// checksum byte must not act as a header
			if (frame_buf[FRAME_LEN] == HDR0 || $urandom_range(0, 9) == 0) begin
				frame_buf.push_back(HDR1);
				frame_buf.push_back(FRAME_LEN);
				frame_buf.push_back(FRAME_TYPE);
			end
		end else if (r < 63) begin
			build_body();
			s = body_sum();
			frame_buf[FRAME_LEN - 1] = frame_buf[FRAME_LEN - 1] + (8'hFF - s);
			case ($urandom_range(0, 3))
				0, 1: frame_buf.push_back(8'h00);
				2: frame_buf.push_back(8'hFF);
				default: frame_buf.push_back(8'($urandom_range(0, 255)));
			endcase
		end else if (r < 73) begin
			build_body();
			s = body_sum() + 8'h01;
			frame_buf.push_back(($urandom_range(0, 3) == 0 && s != HDR0) ? HDR0 :
				s + 8'($urandom_range(1, 255)));
		end else if (r < 85) begin
			case ($urandom_range(0, 2))
				0: begin
					frame_buf = {HDR0};
					repeat ($urandom_range(0, 2)) frame_buf.push_back(HDR0);
					frame_buf.push_back(HDR1);
					frame_buf.push_back(wrong_byte(FRAME_LEN));
				end
				1: frame_buf = {HDR0, HDR1, FRAME_LEN, wrong_byte(FRAME_TYPE)};
				default: begin
					build_good_frame();
					repeat ($urandom_range(1, FRAME_LEN)) void'(frame_buf.pop_back());
				end
			endcase
		end else begin
			frame_buf = {};
			repeat ($urandom_range(1, 6)) begin
				r = $urandom_range(0, 9);
				frame_buf.push_back(r < 3 ? HDR0 : r < 4 ? HDR1 : 8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		bit drained;
		drained     = 1'b0;
		frame_bytes = 0;
		cycle_count = 0;
		rx_if.valid   <= 1'b0;
		rx_if.rx_byte <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray bytes, repeated A5, bad length, A5 in length and type slots,
		// bad type, then a header that runs into the random frames
		frame_buf = {8'h00, 8'hFF, HDR1, HDR0, HDR0, HDR1, 8'h17, HDR0, HDR1, HDR0,
			HDR1, FRAME_LEN, 8'h00, HDR0, HDR1, FRAME_LEN, HDR0, HDR1, FRAME_LEN,
			FRAME_TYPE};
		send_buf();

		while (frame_bytes < ITEM_TARGET) begin
			if (!drained && frame_bytes >= ITEM_TARGET / 2) begin
				drained = 1'b1;
				rx_if.valid <= 1'b0;
				// let the monitor note the last request before looking at the queue
				@(posedge clk);
				while (tracker.expected_samples.size() != 0) @(posedge clk);
			end
			build_chunk();
			send_buf();
		end
		rx_if.valid <= 1'b0;

		@(posedge clk);
		while (tracker.expected_samples.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (tracker.expected_samples.size() != 0)
			$error("%0d samples never produced", tracker.expected_samples.size());
		if (tracker.mismatches == 0 && tracker.expected_samples.size() == 0) begin
			$display("imu_frame_parser_checksum_unit regression: pass");
		end else begin
			$display("imu_frame_parser_checksum_unit regression: fail");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/imufp_pkg.sv
hw/rtl/imufp_byte_if.sv
hw/rtl/imufp_sample_if.sv
hw/rtl/imufp_in_stage.sv
hw/rtl/imufp_parser.sv
hw/rtl/imufp_out_stage.sv
hw/rtl/imu_frame_parser_checksum_unit.sv
sim/imu_frame_parser_checksum_unit_tb.sv
